// ===== design/assert_macros.svh =====
// Assertion macros used by windowed_nearest_path_point_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, prop, msg)

`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ===== design/wnpp_pkg.sv =====
`timescale 1ns / 1ps

package wnpp_pkg;

  localparam int MAX_POINTS_DEF     = 1024;
  localparam int DEFAULT_WINDOW_DEF = 150;

  localparam int COORD_W  = 24;
  localparam int IDX_IN_W = 10;
  localparam int LEN_W    = 11;
  localparam int SPAN_W   = 12;
  localparam int DIST_W   = 2 * COORD_W + 1;
  localparam int S_DATA_W = 96;
  localparam int M_DATA_W = 16;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [LEN_W-1:0] idx;
  } scan_tag_t;

  typedef struct packed {
    logic             done;
    logic [LEN_W-1:0] sel;
  } scan_done_t;

endpackage

// ===== design/wnpp_ram.sv =====
`timescale 1ns / 1ps

module wnpp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/wnpp_scan_unit.sv =====
`timescale 1ns / 1ps

module wnpp_scan_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  wnpp_pkg::scan_tag_t               tag_in,
  input  logic signed [wnpp_pkg::COORD_W-1:0] veh_x,
  input  logic signed [wnpp_pkg::COORD_W-1:0] veh_y,
  input  logic [2*wnpp_pkg::COORD_W-1:0]    pt_data,
  output wnpp_pkg::scan_done_t              done
);
  import wnpp_pkg::*;

  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W   = 2 * COORD_W;

  scan_tag_t tag1, tag2, tag3, tag4;

  logic signed [DIFF_W-1:0]   pt_x, pt_y;
  logic signed [DIFF_W-1:0]   dx, dy;
  logic signed [2*DIFF_W-1:0] prod_x, prod_y;
  logic [SQ_W-1:0]            sqx, sqy;
  logic [DIST_W-1:0]          dist_sum;
  logic [DIST_W-1:0]          best;
  logic [LEN_W-1:0]           best_idx;
  logic                       take;

  assign pt_x   = DIFF_W'(signed'(pt_data[COORD_W-1:0]));
  assign pt_y   = DIFF_W'(signed'(pt_data[2*COORD_W-1:COORD_W]));
  assign prod_x = dx * dx;
  assign prod_y = dy * dy;
  assign take   = tag4.first || (dist_sum < best);

  assign done.done = tag4.valid && tag4.last;
  assign done.sel  = take ? tag4.idx : best_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      tag3 <= '0;
      tag4 <= '0;
    end else begin
      tag1 <= tag_in;
      tag2 <= tag1;
      tag3 <= tag2;
      tag4 <= tag3;
    end
  end

  always_ff @(posedge clk) begin
    dx       <= pt_x - DIFF_W'(veh_x);
    dy       <= pt_y - DIFF_W'(veh_y);
    sqx      <= prod_x[SQ_W-1:0];
    sqy      <= prod_y[SQ_W-1:0];
    dist_sum <= DIST_W'(sqx) + DIST_W'(sqy);
    if (tag4.valid && take) begin
      best     <= dist_sum;
      best_idx <= tag4.idx;
    end
  end

endmodule

// ===== design/windowed_nearest_path_point_unit.sv =====
// Windowed nearest path point search. A word with tuser = 0 stores one waypoint
// (x, y in signed Q15.8) at point_index; indices at or above MAX_POINTS are
// dropped. A word with tuser = 1 is a query: it scans stored points from
// start_index up to start_index + window_len (0 selects DEFAULT_WINDOW), clipped
// to path_len, and returns the first index of smallest squared distance to the
// vehicle, advanced by one when that is the start point and a next point exists.
// The path store has one read port and the distance unit takes one point per
// cycle through its difference, square and sum registers. The input is not ready
// during a query. Reading a point never written gives an undefined answer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module windowed_nearest_path_point_unit #(
  parameter int MAX_POINTS     = wnpp_pkg::MAX_POINTS_DEF,
  parameter int DEFAULT_WINDOW = wnpp_pkg::DEFAULT_WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // point_index[9:0], pos_x[33:10], pos_y[57:34], start_index[67:58],
  // window_len[78:68], path_len[89:79], zero[95:90]
  input  logic [wnpp_pkg::S_DATA_W-1:0] s_tdata,
  // cmd[0]
  input  logic [0:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // closest_index[9:0], zero[15:10]
  output logic [wnpp_pkg::M_DATA_W-1:0] m_tdata
);
  import wnpp_pkg::*;

  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam logic [16:0] MAX_P = 17'(MAX_POINTS);
  localparam logic [LEN_W-1:0] DEF_WIN = LEN_W'(DEFAULT_WINDOW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  state_t state;

  logic [IDX_IN_W-1:0]       in_pidx, in_start;
  logic signed [COORD_W-1:0] in_x, in_y;
  logic [LEN_W-1:0]          in_win, in_plen, win_eff;
  cmd_t                      in_cmd;
  logic [SPAN_W-1:0]         plen_sat, stop_raw, stop_calc;
  logic                      accept, ram_we;

  logic [LEN_W-1:0]          idx;
  logic [SPAN_W-1:0]         stop;
  logic [SPAN_W-1:0]         plen;
  logic [IDX_IN_W-1:0]       start;
  logic signed [COORD_W-1:0] veh_x, veh_y;
  logic [LEN_W-1:0]          sel;
  logic                      adv;
  logic [LEN_W-1:0]          sel_fin;
  logic                      is_last;

  scan_tag_t              tag;
  scan_done_t             unit_done;
  logic [2*COORD_W-1:0]   ram_rdata;

  assign in_pidx  = s_tdata[9:0];
  assign in_x     = s_tdata[33:10];
  assign in_y     = s_tdata[57:34];
  assign in_start = s_tdata[67:58];
  assign in_win   = s_tdata[78:68];
  assign in_plen  = s_tdata[89:79];
  assign in_cmd   = cmd_t'(s_tuser[0]);

  assign s_tready = (state == ST_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;
  assign ram_we   = accept && (in_cmd == CMD_WRITE) && (17'(in_pidx) < MAX_P);

  assign plen_sat  = (17'(in_plen) > MAX_P) ? SPAN_W'(MAX_POINTS) : SPAN_W'(in_plen);
  assign win_eff   = (in_win == '0) ? DEF_WIN : in_win;
  assign stop_raw  = SPAN_W'(in_start) + SPAN_W'(win_eff);
  assign stop_calc = (stop_raw > plen_sat) ? plen_sat : stop_raw;

  assign is_last = (SPAN_W'(idx) + SPAN_W'(1)) == stop;

  always_comb begin
    tag       = '0;
    tag.valid = (state == ST_SCAN);
    tag.first = (idx == LEN_W'(start));
    tag.last  = is_last;
    tag.idx   = idx;
  end

  assign adv     = (sel == LEN_W'(start)) && ((SPAN_W'(sel) + SPAN_W'(1)) < plen);
  assign sel_fin = adv ? sel + LEN_W'(1) : sel;

  wnpp_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (MAX_POINTS)
  ) u_path (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(in_pidx)),
    .wdata ({in_y, in_x}),
    .re    (state == ST_SCAN),
    .raddr (ADDR_W'(idx)),
    .rdata (ram_rdata)
  );

  wnpp_scan_unit u_scan (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (tag),
    .veh_x   (veh_x),
    .veh_y   (veh_y),
    .pt_data (ram_rdata),
    .done    (unit_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == ST_RESULT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (in_cmd == CMD_QUERY)) begin
            veh_x <= in_x;
            veh_y <= in_y;
            start <= in_start;
            plen  <= plen_sat;
            stop  <= stop_calc;
            idx   <= LEN_W'(in_start);
            sel   <= LEN_W'(in_start);
            if (stop_calc > SPAN_W'(in_start)) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_RESULT;
            end
          end
        end
        ST_SCAN: begin
          idx <= idx + LEN_W'(1);
          if (is_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (unit_done.done) begin
            sel   <= unit_done.sel;
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= M_DATA_W'(sel_fin[IDX_IN_W-1:0]);
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_PROP(a_done_in_drain, unit_done.done |-> (state == ST_DRAIN), "scan done outside drain")
  `ASSERT_PROP(a_scan_range, (state == ST_SCAN) |-> (SPAN_W'(idx) < stop), "scan index past stop")
  `ASSERT_PROP(a_load_src, $rose(m_tvalid) |-> ($past(state) == ST_RESULT), "result without query")
  `ASSERT_NEVER(a_write_busy, ram_we && (state != ST_IDLE), "path write during query")

endmodule

// ===== sim/windowed_nearest_path_point_unit_tb.sv =====
`timescale 1ns / 1ps

module windowed_nearest_path_point_unit_tb;
  import wnpp_pkg::*;

  localparam int POINTS = MAX_POINTS_DEF;
  localparam int DEF_WIN = DEFAULT_WINDOW_DEF;
  localparam int LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // point_index[9:0], pos_x[33:10], pos_y[57:34], start_index[67:58],
  // window_len[78:68], path_len[89:79], zero[95:90]
  logic [S_DATA_W-1:0] s_tdata = '0;
  // cmd[0]
  logic [0:0] s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // closest_index[9:0], zero[15:10]
  logic [M_DATA_W-1:0] m_tdata;

  logic signed [23:0] path_x_mirror [POINTS];
  logic signed [23:0] path_y_mirror [POINTS];
  bit point_written [POINTS];
  logic [9:0] closest_q [$];
  logic [9:0] want_index;
  int words_sent = 0;
  int errors = 0;
  int cycle_count = 0;
  int hold_req = 0;
  int hold_left = 0;
  int stall_left = 0;
  bit no_idle = 1'b0;

  windowed_nearest_path_point_unit uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("windowed_nearest_path_point_unit test failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int path_limit(input logic [10:0] plen);
    return (plen > POINTS) ? POINTS : int'(plen);
  endfunction

  function automatic int scan_stop(input logic [9:0] start, input logic [10:0] win,
                                   input logic [10:0] plen);
    int stop;
    stop = int'(start) + ((win == 0) ? DEF_WIN : int'(win));
    return (stop > path_limit(plen)) ? path_limit(plen) : stop;
  endfunction

  function automatic logic [9:0] nearest_index(input logic signed [23:0] vx, vy,
                                               input logic [9:0] start,
                                               input logic [10:0] win, plen);
    int stop, sel, i;
    longint dx, dy, d, best;
    bit found;
    stop = scan_stop(start, win, plen);
    sel = int'(start);
    found = 1'b0;
    best = 0;
    for (i = int'(start); i < stop; i++) begin
      dx = longint'(path_x_mirror[i]) - longint'(vx);
      dy = longint'(path_y_mirror[i]) - longint'(vy);
      d = dx * dx + dy * dy;
      if (!found || d < best) begin
        found = 1'b1;
        best = d;
        sel = i;
      end
    end
    if (sel == int'(start) && sel + 1 < path_limit(plen)) sel++;
    return sel[9:0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR: %s got %0d want %0d at cycle %0d", what, got, want, cycle_count);
    errors++;
  endtask

  task automatic send_word(input cmd_t c, input logic [9:0] pidx,
                           input logic signed [23:0] x, y, input logic [9:0] start,
                           input logic [10:0] win, plen);
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= c;
    s_tdata <= {6'b0, plen, win, start, y, x, pidx};
    do @(posedge clk); while (!s_tready);
    words_sent++;
    if (c == CMD_WRITE) begin
      path_x_mirror[pidx] = x;
      path_y_mirror[pidx] = y;
      point_written[pidx] = 1'b1;
    end else begin
      closest_q.push_back(nearest_index(x, y, start, win, plen));
    end
  endtask

  task automatic write_point(input logic [9:0] idx, input logic signed [23:0] x, y);
    send_word(CMD_WRITE, idx, x, y, 10'($urandom), 11'($urandom), 11'($urandom));
  endtask

  // fill any unwritten point in the scan range first
  task automatic query(input logic signed [23:0] vx, vy, input logic [9:0] start,
                       input logic [10:0] win, plen);
    int i, stop;
    stop = scan_stop(start, win, plen);
    for (i = int'(start); i < stop; i++) begin
      if (!point_written[i]) begin
        if (i > 0 && point_written[i-1])
          write_point(10'(i),
                      24'(int'(path_x_mirror[i-1]) + int'($urandom_range(0, 1023)) - 512),
                      24'(int'(path_y_mirror[i-1]) + int'($urandom_range(0, 1023)) - 512));
        else
          write_point(10'(i), 24'($urandom), 24'($urandom));
      end
    end
    send_word(CMD_QUERY, 10'($urandom), vx, vy, start, win, plen);
  endtask

  function automatic logic [10:0] pick_window(input int span);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return 11'd0;
    if (roll < 8) return 11'($urandom_range(1, span));
    if (roll == 8) return 11'($urandom_range(1024, 2047));
    return 11'($urandom_range(1, 2047));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (closest_q.size() == 0) begin
          report_mismatch("unexpected closest_index", int'(m_tdata[9:0]), 0);
        end else begin
          want_index = closest_q.pop_front();
          if (m_tdata[9:0] !== want_index)
            report_mismatch("closest_index", int'(m_tdata[9:0]), int'(want_index));
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (no_idle) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  task automatic test_directed();
    int k;
    for (k = 0; k < 6; k++) write_point(10'(k), 24'(k * 2560), 24'(-k * 1280));
    write_point(1020, 24'sh000100, 24'sh000100);
    write_point(1021, 24'sh000200, 24'sh000200);
    write_point(1022, 24'sh800000, 24'sh7FFFFF);
    write_point(1023, 24'sh7FFFFF, 24'sh800000);
    query(24'(3 * 2560 + 7), 24'(-3 * 1280 - 3), 0, 6, 6);
    query(0, 0, 0, 6, 6);
    query(24'(5 * 2560), 24'(-5 * 1280), 5, 1, 6);
    query(0, 0, 7, 6, 6);
    query(0, 0, 0, 0, 0);
    write_point(4, 24'(2 * 2560), 24'(-2 * 1280));
    query(24'(2 * 2560), 24'(-2 * 1280), 1, 5, 6);
    query(24'sh7FFFFF, 24'sh800000, 1020, 0, 2047);
    query(24'sh800000, 24'sh800000, 1020, 1024, 1024);
    query(0, 0, 1023, 2047, 1024);
    query(512, 512, 1021, 1, 1024);
  endtask

  // hold the result side while queries keep coming
  task automatic test_backpressure();
    int k;
    no_idle = 1'b1;
    hold_req = 1500;
    for (k = 0; k < 8; k++)
      query(24'(k * 2560), 24'(-k * 1280), 10'($urandom_range(0, 4)), 11'd6, 11'd6);
    no_idle = 1'b0;
  endtask

  task automatic test_random_paths(input int target);
    int roll, n, base, i, q, nq, start, t, x, y;
    logic [10:0] plen;
    while (words_sent < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        write_point(10'($urandom_range(0, POINTS - 1)), 24'($urandom), 24'($urandom));
      end else if (roll < 18) begin
        start = $urandom_range(0, POINTS - 1);
        query(24'($urandom), 24'($urandom), 10'(start), pick_window(16),
              11'($urandom_range(0, 2047)));
      end else begin
        n = ($urandom_range(0, 29) == 0) ? $urandom_range(150, 220) : $urandom_range(2, 24);
        base = $urandom_range(0, POINTS - n);
        x = int'($urandom_range(0, 8388607)) - 4194304;
        y = int'($urandom_range(0, 8388607)) - 4194304;
        for (i = 0; i < n; i++) begin
          write_point(10'(base + i), 24'(x), 24'(y));
          if ($urandom_range(0, 9) != 0) begin
            x += int'($urandom_range(0, 2048)) - 1024;
            y += int'($urandom_range(0, 2048)) - 1024;
          end
        end
        nq = $urandom_range(3, 10);
        for (q = 0; q < nq; q++) begin
          start = base + $urandom_range(0, n - 1);
          roll = $urandom_range(0, 9);
          if (roll < 7) plen = 11'(base + n);
          else if (roll == 7) plen = 11'($urandom_range(0, start));
          else if (roll == 8) plen = 11'(start + 1);
          else plen = 11'($urandom_range(1024, 2047));
          t = ($urandom_range(0, 4) == 0) ? start : $urandom_range(start, base + n - 1);
          x = int'(path_x_mirror[t]);
          y = int'(path_y_mirror[t]);
          if ($urandom_range(0, 3) != 0) begin
            x += int'($urandom_range(0, 600)) - 300;
            y += int'($urandom_range(0, 600)) - 300;
          end
          query(24'(x), 24'(y), 10'(start), pick_window(n), plen);
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random_paths(1300);
    s_tvalid <= 1'b0;
    while (closest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("windowed_nearest_path_point_unit test passed");
    else
      $display("windowed_nearest_path_point_unit test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/wnpp_pkg.sv
design/wnpp_ram.sv
design/wnpp_scan_unit.sv
design/windowed_nearest_path_point_unit.sv
sim/windowed_nearest_path_point_unit_tb.sv
